>>> sv/owm_pkg.sv
`default_nettype none
package owm_pkg;

  localparam int TIMER_BITS_DEF = 10;
  localparam int LEN_W          = 16;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 10;

  localparam logic [LEN_W-1:0] PRE_RESET_TICKS = 16'd10;

  localparam logic [9:0] RESET_LOW_DEF      = 10'd480;
  localparam logic [7:0] PRESENCE_WAIT_DEF  = 8'd60;
  localparam logic [9:0] RESET_RECOVERY_DEF = 10'd420;
  localparam logic [7:0] SLOT_DEF           = 8'd60;
  localparam logic [3:0] READ_SAMPLE_DEF    = 4'd2;
  localparam logic [7:0] BYTE_GAP_DEF       = 8'd100;

  localparam logic [CFG_IDX_W-1:0] CFG_RESET_LOW      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESENCE_WAIT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RESET_RECOVERY = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT           = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_READ_SAMPLE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BYTE_GAP       = 3'd5;

  localparam logic [2:0] OP_NONE     = 3'd0;
  localparam logic [2:0] OP_RESET    = 3'd1;
  localparam logic [2:0] OP_WR_BIT   = 3'd2;
  localparam logic [2:0] OP_RD_BIT   = 3'd3;
  localparam logic [2:0] OP_WR_BYTE  = 3'd4;
  localparam logic [2:0] OP_RD_BYTE  = 3'd5;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_RS_PRE    = 4'd1,
    PH_RS_LOW    = 4'd2,
    PH_RS_WAIT   = 4'd3,
    PH_RS_SAMPLE = 4'd4,
    PH_RS_REC    = 4'd5,
    PH_W_LOW     = 4'd6,
    PH_W_REL     = 4'd7,
    PH_R_LOW     = 4'd8,
    PH_R_WAIT    = 4'd9,
    PH_R_SAMPLE  = 4'd10,
    PH_R_REC     = 4'd11,
    PH_GAP       = 4'd12
  } ph_t;

  typedef struct packed {
    logic [9:0] reset_low_ticks;
    logic [7:0] presence_wait_ticks;
    logic [9:0] reset_recovery_ticks;
    logic [7:0] slot_ticks;
    logic [3:0] read_sample_ticks;
    logic [7:0] byte_gap_ticks;
  } cfg_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] rx_data;
  } res_t;

  typedef struct packed {
    ph_t        ph;
    logic [3:0] bits;
    logic [7:0] sh;
  } step_t;

  // Raw segment length, before the timer-width wrap.
  function automatic logic [LEN_W-1:0] owm_seg_len(ph_t ph, logic one, cfg_t cfg);
    logic [LEN_W-1:0] len;
    case (ph)
      PH_RS_PRE:    len = PRE_RESET_TICKS;
      PH_RS_LOW:    len = LEN_W'(cfg.reset_low_ticks);
      PH_RS_WAIT:   len = LEN_W'(cfg.presence_wait_ticks);
      PH_RS_SAMPLE: len = 16'd1;
      PH_RS_REC:    len = LEN_W'(cfg.reset_recovery_ticks);
      PH_W_LOW:     len = one ? 16'd1 : LEN_W'(cfg.slot_ticks);
      PH_W_REL:     len = (one ? LEN_W'(cfg.slot_ticks) : 16'd1) + LEN_W'(cfg.slot_ticks);
      PH_R_LOW:     len = 16'd1;
      PH_R_WAIT:    len = LEN_W'(cfg.read_sample_ticks);
      PH_R_SAMPLE:  len = 16'd1;
      PH_R_REC:     len = LEN_W'(cfg.slot_ticks);
      PH_GAP:       len = LEN_W'(cfg.byte_gap_ticks);
      default:      len = '0;
    endcase
    return len;
  endfunction

  // Segment that follows ph; the end of a slot counts a bit off.
  function automatic step_t owm_next(ph_t ph, logic pres, logic [3:0] bits,
                                     logic [7:0] sh, logic bmode);
    step_t      s;
    logic [3:0] b;
    s.bits = bits;
    s.sh   = sh;
    b      = bits;
    case (ph)
      PH_RS_PRE:    s.ph = PH_RS_LOW;
      PH_RS_LOW:    s.ph = PH_RS_WAIT;
      PH_RS_WAIT:   s.ph = PH_RS_SAMPLE;
      PH_RS_SAMPLE: s.ph = pres ? PH_RS_REC : PH_IDLE;
      PH_W_LOW:     s.ph = PH_W_REL;
      PH_R_LOW:     s.ph = PH_R_WAIT;
      PH_R_WAIT:    s.ph = PH_R_SAMPLE;
      PH_R_SAMPLE:  s.ph = PH_R_REC;
      PH_W_REL, PH_R_REC: begin
        if (b != 4'd0) b = b - 4'd1;
        s.bits = b;
        if (b != 4'd0) begin
          if (ph == PH_W_REL) begin
            s.sh = {1'b0, sh[7:1]};
            s.ph = PH_W_LOW;
          end else begin
            s.ph = PH_R_LOW;
          end
        end else begin
          s.ph = (ph == PH_W_REL && bmode) ? PH_GAP : PH_IDLE;
        end
      end
      default:      s.ph = PH_IDLE;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

>>> sv/owm_in_if.sv
`default_nettype none
interface owm_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] op;
  logic [7:0] tx_byte;
  logic       line_level;

  modport source (output valid, output op, output tx_byte, output line_level, input ready);
  modport sink   (input valid, input op, input tx_byte, input line_level, output ready);
endinterface
`default_nettype wire

>>> sv/owm_out_if.sv
`default_nettype none
interface owm_out_if;
  logic       valid;
  logic       ready;
  logic       drive_low;
  logic       busy_res;
  logic       done_res;
  logic       presence;
  logic [7:0] rx_data;

  modport source (output valid, output drive_low, output busy_res, output done_res,
                  output presence, output rx_data, input ready);
  modport sink   (input valid, input drive_low, input busy_res, input done_res,
                  input presence, input rx_data, output ready);
endinterface
`default_nettype wire

>>> sv/owm_core.sv
`default_nettype none
module owm_core
  import owm_pkg::*;
#(
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       tick_en,
  input  wire logic [2:0] op,
  input  wire logic [7:0] tx_byte,
  input  wire logic       line_level,
  input  wire cfg_t       cfg,
  output res_t            res
);

  ph_t                   phase_r, phase_nxt, cur_ph;
  logic [TIMER_BITS-1:0] cnt_r, cnt_nxt;
  logic [3:0]            bits_r, bits_nxt;
  logic [7:0]            sh_r, sh_nxt;
  logic                  bmode_r, bmode_nxt;
  logic                  pres_r, pres_nxt;

  // next state
  always_comb begin
    step_t                 st;
    logic [LEN_W-1:0]      raw;
    logic [TIMER_BITS-1:0] len;
    logic                  found;
    cur_ph    = phase_r;
    cnt_nxt   = cnt_r;
    bits_nxt  = bits_r;
    sh_nxt    = sh_r;
    bmode_nxt = bmode_r;
    pres_nxt  = pres_r;
    st        = '0;
    raw       = '0;
    len       = '0;
    found     = 1'b0;

    if (phase_r == PH_IDLE && (op inside {[OP_RESET:OP_RD_BYTE]})) begin
      bmode_nxt = (op >= OP_WR_BYTE);
      bits_nxt  = bmode_nxt ? 4'd8 : 4'd1;
      case (op)
        OP_RESET: begin
          cur_ph  = PH_RS_PRE;
          cnt_nxt = PRE_RESET_TICKS[TIMER_BITS-1:0];
        end
        OP_WR_BIT, OP_WR_BYTE: begin
          sh_nxt = (op == OP_WR_BIT) ? {7'b0, tx_byte[0]} : tx_byte;
          if (sh_nxt[0] || cfg.slot_ticks != 8'd0) begin
            cur_ph  = PH_W_LOW;
            cnt_nxt = sh_nxt[0] ? TIMER_BITS'(1) : TIMER_BITS'(cfg.slot_ticks);
          end else begin
            cur_ph  = PH_W_REL;
            cnt_nxt = TIMER_BITS'(1);
          end
        end
        default: begin
          sh_nxt  = 8'd0;
          cur_ph  = PH_R_LOW;
          cnt_nxt = TIMER_BITS'(1);
        end
      endcase
    end

    phase_nxt = cur_ph;
    if (cur_ph != PH_IDLE) begin
      if (cur_ph == PH_RS_SAMPLE) pres_nxt = ~line_level;
      if (cur_ph == PH_R_SAMPLE) sh_nxt = bmode_nxt ? {line_level, sh_nxt[7:1]}
                                                    : {7'b0, line_level};
      cnt_nxt = cnt_nxt - TIMER_BITS'(1);
      if (cnt_nxt == '0) begin
        st = owm_next(cur_ph, pres_nxt, bits_nxt, sh_nxt, bmode_nxt);
        // zero-length segments are skipped; at most three in a row
        for (int i = 0; i < 4; i++) begin
          if (!found) begin
            if (st.ph == PH_IDLE) begin
              found = 1'b1;
            end else begin
              raw = owm_seg_len(st.ph, st.sh[0], cfg);
              len = raw[TIMER_BITS-1:0];
              if (len != '0) begin
                found   = 1'b1;
                cnt_nxt = len;
              end else begin
                st = owm_next(st.ph, pres_nxt, st.bits, st.sh, bmode_nxt);
              end
            end
          end
        end
        bits_nxt  = st.bits;
        sh_nxt    = st.sh;
        phase_nxt = found ? st.ph : PH_IDLE;
        if (phase_nxt == PH_IDLE) cnt_nxt = '0;
      end
    end
  end

  // outputs
  always_comb begin
    res.drive_low = (cur_ph == PH_RS_LOW) || (cur_ph == PH_W_LOW) || (cur_ph == PH_R_LOW);
    res.busy_res  = (cur_ph != PH_IDLE);
    res.done_res  = res.busy_res && (phase_nxt == PH_IDLE);
    res.presence  = pres_nxt;
    res.rx_data   = (res.done_res && (cur_ph inside {[PH_R_LOW:PH_R_REC]})) ? sh_nxt : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cnt_r   <= '0;
      bits_r  <= '0;
      sh_r    <= '0;
      bmode_r <= 1'b0;
      pres_r  <= 1'b0;
    end else if (tick_en) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      bits_r  <= bits_nxt;
      sh_r    <= sh_nxt;
      bmode_r <= bmode_nxt;
      pres_r  <= pres_nxt;
    end
  end

endmodule
`default_nettype wire

>>> sv/one_wire_bus_master.sv
// 1-Wire bus master, timed by one input transaction per microsecond tick.
// in_if carries op, tx_byte and the sampled line_level for that tick; each
// input transaction yields exactly one out_if transaction with drive_low,
// busy_res, done_res, presence and rx_data for the same tick.
// A command starts on the tick it arrives while idle; ops seen while busy
// are ignored. rx_data is nonzero only on the done tick of a read.
// The result is registered: it is valid the cycle after the input transaction.
// Throughput: one tick per clock unless stalled; the segment timer and
// phase update once per transaction through a single register stage.
// Stall: the output register holds its result while out_if.ready is low;
// in_if.ready then drops, and rises again as soon as the result is taken.
// Reset (rst_n low, synchronous; res_r is not reset): the sequencer goes
// idle, presence clears and all timing registers return to their defaults.
// cfg_we writes cfg_wdata into register cfg_index (0 reset low, 1 presence
// wait, 2 reset recovery, 3 slot, 4 read sample, 5 byte gap); write only
// while idle.
`default_nettype none
module one_wire_bus_master
  import owm_pkg::*;
#(
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  owm_in_if.sink                     in_if,
  owm_out_if.source                  out_if,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t cfg_r;
  res_t res, res_r;
  logic out_valid_r;
  logic accept;

  assign in_if.ready = !out_valid_r || out_if.ready;
  assign accept      = in_if.valid && in_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reset_low_ticks      <= RESET_LOW_DEF;
      cfg_r.presence_wait_ticks  <= PRESENCE_WAIT_DEF;
      cfg_r.reset_recovery_ticks <= RESET_RECOVERY_DEF;
      cfg_r.slot_ticks           <= SLOT_DEF;
      cfg_r.read_sample_ticks    <= READ_SAMPLE_DEF;
      cfg_r.byte_gap_ticks       <= BYTE_GAP_DEF;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RESET_LOW:      cfg_r.reset_low_ticks      <= cfg_wdata;
        CFG_PRESENCE_WAIT:  cfg_r.presence_wait_ticks  <= cfg_wdata[7:0];
        CFG_RESET_RECOVERY: cfg_r.reset_recovery_ticks <= cfg_wdata;
        CFG_SLOT:           cfg_r.slot_ticks           <= cfg_wdata[7:0];
        CFG_READ_SAMPLE:    cfg_r.read_sample_ticks    <= cfg_wdata[3:0];
        CFG_BYTE_GAP:       cfg_r.byte_gap_ticks       <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  owm_core #(
    .TIMER_BITS (TIMER_BITS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .tick_en    (accept),
    .op         (in_if.op),
    .tx_byte    (in_if.tx_byte),
    .line_level (in_if.line_level),
    .cfg        (cfg_r),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res;
    end
  end

  assign out_if.valid     = out_valid_r;
  assign out_if.drive_low = res_r.drive_low;
  assign out_if.busy_res  = res_r.busy_res;
  assign out_if.done_res  = res_r.done_res;
  assign out_if.presence  = res_r.presence;
  assign out_if.rx_data   = res_r.rx_data;

endmodule
`default_nettype wire

>>> sv/owm_chk.sv
`default_nettype none
module owm_chk (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       drive_low,
  input wire logic       busy_res,
  input wire logic       done_res,
  input wire logic       presence,
  input wire logic [7:0] rx_data
);

  a_reset_clears_valid: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out valid after reset");

  a_done_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (done_res || drive_low) |-> busy_res)
    else $error("done or drive_low outside a command");

  a_rx_only_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !done_res |-> rx_data == 8'd0)
    else $error("rx_data nonzero off the done tick");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(drive_low) && $stable(busy_res)
      && $stable(done_res) && $stable(presence) && $stable(rx_data))
    else $error("stalled transaction changed");

endmodule

bind one_wire_bus_master owm_chk u_owm_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .drive_low (out_if.drive_low),
  .busy_res  (out_if.busy_res),
  .done_res  (out_if.done_res),
  .presence  (out_if.presence),
  .rx_data   (out_if.rx_data)
);
`default_nettype wire

>>> bench/one_wire_bus_master_tb.sv
`default_nettype none
module one_wire_bus_master_tb;
  import owm_pkg::*;

  localparam int TB_TIMER_BITS = TIMER_BITS_DEF;
  localparam int QUIET_LIMIT   = 1000;
  localparam int SHOW_LIMIT    = 10;

  // op codes the block has no meaning for
  localparam logic [2:0] OP_UNUSED_6 = 3'd6;
  localparam logic [2:0] OP_UNUSED_7 = 3'd7;

  typedef enum int {LINE_HIGH, LINE_LOW, LINE_RAND} line_mode_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  owm_in_if  in_ch ();
  owm_out_if out_ch ();

  one_wire_bus_master uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // bus sequencer state as the bench sees it
  ph_t                    bus_ph;
  logic [TB_TIMER_BITS-1:0] bus_cnt;
  logic [3:0]             bus_bits;
  logic [7:0]             bus_shift;
  logic                   bus_bytemode;
  logic                   bus_pres;

  logic [9:0] t_rst_low;
  logic [7:0] t_pres_wait;
  logic [9:0] t_rst_rec;
  logic [7:0] t_slot;
  logic [3:0] t_rd_sample;
  logic [7:0] t_gap;

  res_t tick_results_q[$];
  int   mismatches;
  int   quiet_cycles;
  bit   gaps_on;
  bit   stall_on;

  function automatic int unsigned seg_ticks(ph_t p);
    int unsigned len;
    case (p)
      PH_RS_PRE:    len = 32'(PRE_RESET_TICKS);
      PH_RS_LOW:    len = 32'(t_rst_low);
      PH_RS_WAIT:   len = 32'(t_pres_wait);
      PH_RS_SAMPLE: len = 1;
      PH_RS_REC:    len = 32'(t_rst_rec);
      PH_W_LOW:     len = bus_shift[0] ? 1 : 32'(t_slot);
      PH_W_REL:     len = (bus_shift[0] ? 32'(t_slot) : 1) + 32'(t_slot);
      PH_R_LOW:     len = 1;
      PH_R_WAIT:    len = 32'(t_rd_sample);
      PH_R_SAMPLE:  len = 1;
      PH_R_REC:     len = 32'(t_slot);
      PH_GAP:       len = 32'(t_gap);
      default:      len = 0;
    endcase
    return len & ((1 << TB_TIMER_BITS) - 1);
  endfunction

  function automatic ph_t after_seg(ph_t p);
    ph_t nxt;
    case (p)
      PH_RS_PRE:    nxt = PH_RS_LOW;
      PH_RS_LOW:    nxt = PH_RS_WAIT;
      PH_RS_WAIT:   nxt = PH_RS_SAMPLE;
      PH_RS_SAMPLE: nxt = bus_pres ? PH_RS_REC : PH_IDLE;
      PH_W_LOW:     nxt = PH_W_REL;
      PH_R_LOW:     nxt = PH_R_WAIT;
      PH_R_WAIT:    nxt = PH_R_SAMPLE;
      PH_R_SAMPLE:  nxt = PH_R_REC;
      PH_W_REL, PH_R_REC: begin
        if (bus_bits != 4'd0) bus_bits = bus_bits - 4'd1;
        if (bus_bits != 4'd0) begin
          if (p == PH_W_REL) begin
            bus_shift = bus_shift >> 1;
            nxt = PH_W_LOW;
          end else begin
            nxt = PH_R_LOW;
          end
        end else begin
          nxt = (p == PH_W_REL && bus_bytemode) ? PH_GAP : PH_IDLE;
        end
      end
      default:      nxt = PH_IDLE;
    endcase
    return nxt;
  endfunction

  // zero-length segments are passed over without spending a tick
  function automatic void open_seg(ph_t p);
    int unsigned len;
    ph_t q;
    q = p;
    while (q != PH_IDLE) begin
      len = seg_ticks(q);
      if (len != 0) begin
        bus_ph  = q;
        bus_cnt = TB_TIMER_BITS'(len);
        return;
      end
      q = after_seg(q);
    end
    bus_ph  = PH_IDLE;
    bus_cnt = '0;
  endfunction

  function automatic res_t bus_tick(logic [2:0] op, logic [7:0] tx, logic line);
    res_t r;
    ph_t  cur;
    logic rd;
    r = '0;
    if (bus_ph == PH_IDLE && op >= OP_RESET && op <= OP_RD_BYTE) begin
      bus_bytemode = (op == OP_WR_BYTE || op == OP_RD_BYTE);
      bus_bits     = bus_bytemode ? 4'd8 : 4'd1;
      case (op)
        OP_RESET: begin
          open_seg(PH_RS_PRE);
        end
        OP_WR_BIT: begin
          bus_shift = {7'd0, tx[0]};
          open_seg(PH_W_LOW);
        end
        OP_WR_BYTE: begin
          bus_shift = tx;
          open_seg(PH_W_LOW);
        end
        default: begin
          bus_shift = 8'd0;
          open_seg(PH_R_LOW);
        end
      endcase
    end
    cur = bus_ph;
    if (cur != PH_IDLE) begin
      r.busy_res  = 1'b1;
      r.drive_low = (cur == PH_RS_LOW || cur == PH_W_LOW || cur == PH_R_LOW);
      rd = (cur >= PH_R_LOW && cur <= PH_R_REC);
      if (cur == PH_RS_SAMPLE) bus_pres = !line;
      if (cur == PH_R_SAMPLE)
        bus_shift = bus_bytemode ? {line, bus_shift[7:1]} : {7'd0, line};
      bus_cnt = bus_cnt - TB_TIMER_BITS'(1);
      if (bus_cnt == '0) open_seg(after_seg(cur));
      if (bus_ph == PH_IDLE) begin
        r.done_res = 1'b1;
        if (rd) r.rx_data = bus_shift;
      end
    end
    r.presence = bus_pres;
    return r;
  endfunction

  function automatic logic line_for(line_mode_t mode);
    case (mode)
      LINE_HIGH: return 1'b1;
      LINE_LOW:  return 1'b0;
      default:   return 1'($urandom_range(0, 1));
    endcase
  endfunction

  task automatic send_tick(input logic [2:0] op, input logic [7:0] tx, input logic line);
    int gap;
    gap = gaps_on ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.op         <= op;
    in_ch.tx_byte    <= tx;
    in_ch.line_level <= line;
    do @(posedge clk); while (!in_ch.ready);
    tick_results_q.push_back(bus_tick(op, tx, line));
  endtask

  // start a command and clock it through to done; ops during busy are noise
  task automatic run_cmd(input logic [2:0] op, input logic [7:0] tx, input line_mode_t mode);
    send_tick(op, tx, line_for(mode));
    while (bus_ph != PH_IDLE)
      send_tick(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)), line_for(mode));
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (tick_results_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_timing(input logic [9:0] rl, input logic [7:0] pw, input logic [9:0] rr,
                            input logic [7:0] sl, input logic [3:0] rs, input logic [7:0] gp);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_RESET_LOW;
    cfg_wdata <= rl;
    @(posedge clk);
    cfg_index <= CFG_PRESENCE_WAIT;
    cfg_wdata <= CFG_DATA_W'(pw);
    @(posedge clk);
    cfg_index <= CFG_RESET_RECOVERY;
    cfg_wdata <= rr;
    @(posedge clk);
    cfg_index <= CFG_SLOT;
    cfg_wdata <= CFG_DATA_W'(sl);
    @(posedge clk);
    cfg_index <= CFG_READ_SAMPLE;
    cfg_wdata <= CFG_DATA_W'(rs);
    @(posedge clk);
    cfg_index <= CFG_BYTE_GAP;
    cfg_wdata <= CFG_DATA_W'(gp);
    @(posedge clk);
    cfg_we      <= 1'b0;
    t_rst_low   = rl;
    t_pres_wait = pw;
    t_rst_rec   = rr;
    t_slot      = sl;
    t_rd_sample = rs;
    t_gap       = gp;
  endtask

  task automatic test_default_timing();
    gaps_on  = 1'b1;
    stall_on = 1'b1;
    run_cmd(OP_RD_BIT, 8'h00, LINE_RAND);
  endtask

  task automatic test_each_op();
    set_timing(10'd12, 8'd5, 10'd7, 8'd3, 4'd2, 8'd4);
    run_cmd(OP_RESET, 8'h00, LINE_HIGH);
    run_cmd(OP_RESET, 8'h00, LINE_LOW);
    run_cmd(OP_WR_BIT, 8'hFE, LINE_RAND);
    run_cmd(OP_WR_BIT, 8'h01, LINE_RAND);
    run_cmd(OP_WR_BYTE, 8'hA5, LINE_RAND);
    run_cmd(OP_RD_BIT, 8'h00, LINE_LOW);
    run_cmd(OP_RD_BIT, 8'hFF, LINE_HIGH);
    run_cmd(OP_RD_BYTE, 8'h5A, LINE_RAND);
    send_tick(OP_NONE, 8'hFF, 1'b0);
    send_tick(OP_UNUSED_6, 8'h81, 1'b1);
    send_tick(OP_UNUSED_7, 8'h7E, 1'b0);
  endtask

  task automatic test_zero_segments();
    set_timing(10'd3, 8'd2, 10'd0, 8'd2, 4'd0, 8'd0);
    run_cmd(OP_RESET, 8'h00, LINE_LOW);
    run_cmd(OP_RD_BIT, 8'h00, LINE_RAND);
    run_cmd(OP_WR_BYTE, 8'h3C, LINE_RAND);
  endtask

  task automatic test_extreme_timing();
    set_timing(10'd1, 8'd1, 10'd0, 8'd1, 4'd15, 8'd0);
    run_cmd(OP_RESET, 8'h00, LINE_LOW);
    run_cmd(OP_WR_BIT, 8'h00, LINE_RAND);
    run_cmd(OP_RD_BIT, 8'h00, LINE_RAND);
  endtask

  task automatic test_random_traffic();
    int         k;
    logic [2:0] op;
    line_mode_t mode;
    for (int round = 0; round < 4; round++) begin
      set_timing(10'($urandom_range(1, 8)), 8'($urandom_range(1, 4)),
                 10'($urandom_range(0, 6)), 8'($urandom_range(1, 3)),
                 4'($urandom_range(0, 3)), 8'($urandom_range(0, 6)));
      gaps_on  = ($urandom_range(0, 3) != 0);
      stall_on = ($urandom_range(0, 3) != 0);
      for (int n = 0; n < 4; n++) begin
        k = $urandom_range(0, 9);
        if (k < 8) begin
          k = $urandom_range(0, 3);
          mode = (k == 0) ? LINE_HIGH : (k == 1) ? LINE_LOW : LINE_RAND;
          run_cmd(3'($urandom_range(OP_RESET, OP_RD_BYTE)), 8'($urandom_range(0, 255)), mode);
        end else begin
          k  = $urandom_range(0, 2);
          op = (k == 0) ? OP_NONE : (k == 1) ? OP_UNUSED_6 : OP_UNUSED_7;
          send_tick(op, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end
      end
    end
  endtask

  initial begin
    int gap;
    out_ch.ready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      gap = stall_on ? $urandom_range(0, 19) : 0;
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.drive_low = out_ch.drive_low;
      got.busy_res  = out_ch.busy_res;
      got.done_res  = out_ch.done_res;
      got.presence  = out_ch.presence;
      got.rx_data   = out_ch.rx_data;
      if (tick_results_q.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOW_LIMIT)
          $display("unexpected transaction: drive=%0d busy=%0d done=%0d pres=%0d rx=%02h",
                   got.drive_low, got.busy_res, got.done_res, got.presence, got.rx_data);
      end else begin
        want = tick_results_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= SHOW_LIMIT) begin
            $display("mismatch: exp drive=%0d busy=%0d done=%0d pres=%0d rx=%02h",
                     want.drive_low, want.busy_res, want.done_res, want.presence,
                     want.rx_data);
            $display("          got drive=%0d busy=%0d done=%0d pres=%0d rx=%02h",
                     got.drive_low, got.busy_res, got.done_res, got.presence, got.rx_data);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles = 0;
    else
      quiet_cycles = quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    mismatches   = 0;
    quiet_cycles = 0;
    gaps_on      = 1'b0;
    stall_on     = 1'b0;
    bus_ph       = PH_IDLE;
    bus_cnt      = '0;
    bus_bits     = 4'd0;
    bus_shift    = 8'd0;
    bus_bytemode = 1'b0;
    bus_pres     = 1'b0;
    t_rst_low    = RESET_LOW_DEF;
    t_pres_wait  = PRESENCE_WAIT_DEF;
    t_rst_rec    = RESET_RECOVERY_DEF;
    t_slot       = SLOT_DEF;
    t_rd_sample  = READ_SAMPLE_DEF;
    t_gap        = BYTE_GAP_DEF;
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.op         <= OP_NONE;
    in_ch.tx_byte    <= 8'd0;
    in_ch.line_level <= 1'b1;
    cfg_we           <= 1'b0;
    cfg_index        <= CFG_RESET_LOW;
    cfg_wdata        <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_default_timing();
    test_each_op();
    test_zero_segments();
    test_extreme_timing();
    test_random_traffic();

    settle();
    repeat (5) @(posedge clk);
    if (mismatches == 0 && tick_results_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> files.f
sv/owm_pkg.sv
sv/owm_in_if.sv
sv/owm_out_if.sv
sv/owm_core.sv
sv/one_wire_bus_master.sv
sv/owm_chk.sv
bench/one_wire_bus_master_tb.sv
